// File: rtl/height_grid_binning_core_macros.svh
// Assertion helpers for the height grid binning core.
`ifndef HEIGHT_GRID_BINNING_CORE_MACROS_SVH
`define HEIGHT_GRID_BINNING_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HGB_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define HGB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HGB_ASSERT_IMPLY(name, ante, cons, msg)
`define HGB_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: rtl/hgb_pkg.sv
package hgb_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 64;
	localparam int CELL_CAP_DEF = 64;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		REG_FORWARD = 2'd0,
		REG_ACROSS  = 2'd1,
		REG_SIZE    = 2'd2,
		REG_OFFSET  = 2'd3
	} reg_t;

	localparam logic [5:0]  FORWARD_RST = 6'd32;
	localparam logic [5:0]  ACROSS_RST  = 6'd63;
	localparam logic [13:0] SIZE_RST    = 14'd100;
	localparam logic [15:0] OFFSET_RST  = 16'd0;

	// The tail length is ceil(n / 20), formed as (n + 19) / 20 through a
	// multiply by 3277 / 65536, which is exact for every n below 16000.
	localparam int TAIL_BIAS  = 19;
	localparam int TAIL_RECIP = 3277;
	localparam int TAIL_SHIFT = 16;

	localparam int HEIGHT_W = 17;
	localparam int COORD_W  = 16;
	localparam int SIZE_W   = 14;
	localparam int COLNUM_W = 22;

endpackage

// File: rtl/height_grid_binning_core.sv
// Add point: the row and column divides, the cell read, then a scan and compare for each
// stored height that moves down. Read: the cell read, the mean divide, then the top and
// bottom ceil(n / 20) heights each summed and divided on the shared one-bit-a-cycle divider.
// Clear: all MAX_ROWS * MAX_COLS cells, one cell per cycle through the cell memory.
// One item is in work at a time. After reset the same clearing pass runs (2048 cells at the
// default size) before the first item is taken; configuration writes are taken at any time.
`include "height_grid_binning_core_macros.svh"

module height_grid_binning_core #(
	parameter int MAX_ROWS = hgb_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = hgb_pkg::MAX_COLS_DEF,
	parameter int CELL_CAP = hgb_pkg::CELL_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] pos_forward_mm, [31:16] pos_left_mm, [47:32] pos_down_mm,
	// [52:48] cell_row, [58:53] cell_col, [63:59] zero
	input  logic [63:0] s_axis_tdata,
	// [1:0] req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [6:0] point_count, [23:7] mean_height_mm, [40:24] top_mean_mm,
	// [57:41] bottom_mean_mm, [58] overflowed, [63:59] zero
	output logic [63:0] m_axis_tdata,
	// [0] status
	output logic        m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int NCELL = MAX_ROWS * MAX_COLS;
	localparam int CAW   = (NCELL > 1) ? $clog2(NCELL) : 1;
	localparam int CNTW  = $clog2(CELL_CAP + 1);
	localparam int CIW   = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
	localparam int LAW   = (NCELL * CELL_CAP > 1) ? $clog2(NCELL * CELL_CAP) : 1;
	localparam int HW    = hgb_pkg::HEIGHT_W;
	localparam int SW    = HW + CNTW;
	localparam int CWW   = 1 + SW + CNTW;
	localparam int DVW   = (SW > hgb_pkg::COLNUM_W) ? SW : hgb_pkg::COLNUM_W;
	localparam int DDW   = (CNTW > hgb_pkg::SIZE_W + 1) ? CNTW : hgb_pkg::SIZE_W + 1;
	localparam int DCW   = $clog2(DVW + 1);

	typedef enum logic [18:0] {
		S_CLR      = 19'h00001,
		S_IDLE     = 19'h00002,
		S_PROW     = 19'h00004,
		S_PCOL     = 19'h00008,
		S_PCELL_RD = 19'h00010,
		S_PCELL    = 19'h00020,
		S_PSCAN    = 19'h00040,
		S_PCMP     = 19'h00080,
		S_RCELL_RD = 19'h00100,
		S_RCELL    = 19'h00200,
		S_RMEAN    = 19'h00400,
		S_RK       = 19'h00800,
		S_RTOP_RD  = 19'h01000,
		S_RTOP_AC  = 19'h02000,
		S_RTOPDIV  = 19'h04000,
		S_RBOT_RD  = 19'h08000,
		S_RBOT_AC  = 19'h10000,
		S_RBOTDIV  = 19'h20000,
		S_OUT      = 19'h40000
	} state_t;

	state_t state_q;

	logic [5:0]  cfg_fwd_q;
	logic [5:0]  cfg_across_q;
	logic [13:0] cfg_size_q;
	logic [15:0] cfg_off_q;

	logic [8:0]  rows_use;
	logic [8:0]  cols_use;
	logic [13:0] res_mm;

	logic [CAW-1:0] clr_cnt_q;
	logic [CAW-1:0] cell_q;
	logic [CAW-1:0] row_idx_q;
	logic           row_ok_q;
	logic signed [HW-1:0]    h_q;
	logic signed [15:0]      left_q;
	logic [CIW-1:0]  j_q;
	logic [CNTW-1:0] n_q;
	logic [CNTW-1:0] k_q;
	logic [CNTW-1:0] i_q;
	logic [CNTW-1:0] cur_cnt_q;
	logic [SW-1:0]   cur_sum_q;
	logic            cur_ovf_q;
	logic signed [SW-1:0] acc_q;
	logic signed [SW-1:0] acc_new;
	logic [23:0]     k_prod;

	logic            r_status_q;
	logic [6:0]      r_cnt_q;
	logic [HW-1:0]   r_mean_q;
	logic [HW-1:0]   r_top_q;
	logic [HW-1:0]   r_bot_q;
	logic            r_ovf_q;
	logic            m_valid_q;
	logic [63:0]     m_data_q;
	logic            m_user_q;

	// Shared restoring divider, one quotient bit per cycle.
	logic [DDW-1:0] div_rem_q;
	logic [DVW-1:0] div_quo_q;
	logic [DDW-1:0] div_den_q;
	logic [DCW-1:0] div_cnt_q;
	logic           div_run_q;
	logic           div_neg_q;
	logic [DDW:0]   div_trial;
	logic           div_ge;
	logic [DVW-1:0] div_sres;

	logic [CWW-1:0] cell_mem [NCELL];
	logic [CWW-1:0] cell_rdata_q;
	logic           cell_we;
	logic [CAW-1:0] cell_wa;
	logic [CWW-1:0] cell_wd;
	logic [HW-1:0]  list_mem [NCELL * CELL_CAP];
	logic [HW-1:0]  list_rdata_q;
	logic           list_we;
	logic [LAW-1:0] list_wa;
	logic [HW-1:0]  list_wd;
	logic [LAW-1:0] list_ra;
	logic [LAW-1:0] lbase;

	logic            in_xfer;
	logic            out_go;
	logic [16:0]     fwd_mag;
	logic signed [DVW-1:0] col_num;
	logic [DVW-1:0]  col_mag;
	logic            rd_in_grid;
	logic [CNTW-1:0] rd_cnt;
	logic [SW-1:0]   rd_sum;
	logic            rd_ovf;
	logic [SW-1:0]   sum_mag;
	logic [SW-1:0]   acc_mag;
	logic            ins_pos_hit;
	logic [CWW-1:0]  ins_word;

	assign rows_use = (cfg_fwd_q < 6'(MAX_ROWS > 63 ? 63 : MAX_ROWS)) || (MAX_ROWS > 63) ?
		9'(cfg_fwd_q) : 9'(MAX_ROWS);
	assign cols_use = (cfg_across_q < 6'(MAX_COLS > 63 ? 63 : MAX_COLS)) || (MAX_COLS > 63) ?
		9'(cfg_across_q) : 9'(MAX_COLS);
	assign res_mm = (cfg_size_q == '0) ? 14'd1 : cfg_size_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_go        = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	assign fwd_mag = s_axis_tdata[15] ? (17'd0 - {1'b1, s_axis_tdata[15:0]})
		: {1'b0, s_axis_tdata[15:0]};
	assign col_num = DVW'($signed({left_q, 1'b0})) + $signed(DVW'(cfg_across_q * res_mm));
	assign col_mag = col_num[DVW-1] ? DVW'(-col_num) : DVW'(col_num);
	assign rd_in_grid = (9'(s_axis_tdata[52:48]) < rows_use)
		&& (9'(s_axis_tdata[58:53]) < cols_use);

	assign rd_cnt  = cell_rdata_q[CNTW-1:0];
	assign rd_sum  = cell_rdata_q[CNTW +: SW];
	assign rd_ovf  = cell_rdata_q[CWW-1];
	assign sum_mag = rd_sum[SW-1] ? (SW'(0) - rd_sum) : rd_sum;
	assign acc_new = acc_q + SW'($signed(list_rdata_q));
	assign acc_mag = acc_new[SW-1] ? SW'(-acc_new) : SW'(acc_new);
	assign k_prod  = (24'(n_q) + 24'(hgb_pkg::TAIL_BIAS)) * 24'(hgb_pkg::TAIL_RECIP);

	assign div_trial = {div_rem_q, div_quo_q[DVW-1]};
	assign div_ge    = (div_trial >= {1'b0, div_den_q});
	assign div_sres  = div_neg_q ? (DVW'(0) - div_quo_q) : div_quo_q;

	assign lbase       = LAW'(cell_q) * LAW'(CELL_CAP);
	assign ins_pos_hit = (state_q == S_PCMP) && ($signed(list_rdata_q) < h_q);
	assign ins_word    = {cur_ovf_q, cur_sum_q + SW'(h_q), cur_cnt_q + CNTW'(1)};

	always_comb begin
		cell_we = 1'b0;
		cell_wa = cell_q;
		cell_wd = ins_word;
		list_we = 1'b0;
		list_wa = lbase + LAW'(j_q);
		list_wd = h_q;
		list_ra = lbase + LAW'(i_q);
		case (state_q)
			S_CLR: begin
				cell_we = 1'b1;
				cell_wa = clr_cnt_q;
				cell_wd = '0;
			end
			S_PCELL: begin
				if (rd_cnt >= CNTW'(CELL_CAP)) begin
					cell_we = 1'b1;
					cell_wd = {1'b1, rd_sum, rd_cnt};
				end
			end
			S_PSCAN: begin
				list_ra = lbase + LAW'(j_q) - LAW'(1);
				if (j_q == '0) begin
					list_we = 1'b1;
					cell_we = 1'b1;
				end
			end
			S_PCMP: begin
				list_we = 1'b1;
				if (ins_pos_hit) begin
					list_wd = list_rdata_q;
				end else begin
					cell_we = 1'b1;
				end
			end
			S_RBOT_RD: begin
				list_ra = lbase + LAW'(n_q - CNTW'(1) - i_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[cell_wa] <= cell_wd;
		end
		cell_rdata_q <= cell_mem[cell_q];
	end

	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_wa] <= list_wd;
		end
		list_rdata_q <= list_mem[list_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_fwd_q    <= hgb_pkg::FORWARD_RST;
			cfg_across_q <= hgb_pkg::ACROSS_RST;
			cfg_size_q   <= hgb_pkg::SIZE_RST;
			cfg_off_q    <= hgb_pkg::OFFSET_RST;
		end else if (cfg_valid) begin
			case (hgb_pkg::reg_t'(cfg_index))
				hgb_pkg::REG_FORWARD: cfg_fwd_q    <= cfg_data[5:0];
				hgb_pkg::REG_ACROSS:  cfg_across_q <= cfg_data[5:0];
				hgb_pkg::REG_SIZE:    cfg_size_q   <= cfg_data[13:0];
				hgb_pkg::REG_OFFSET:  cfg_off_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (div_run_q) begin
			div_rem_q <= div_ge ? DDW'(div_trial - {1'b0, div_den_q}) : DDW'(div_trial);
			div_quo_q <= {div_quo_q[DVW-2:0], div_ge};
			div_cnt_q <= div_cnt_q + DCW'(1);
			if (div_cnt_q == DCW'(DVW - 1)) begin
				div_run_q <= 1'b0;
			end
		end else begin
			div_rem_q <= '0;
			div_cnt_q <= '0;
			case (state_q)
				S_IDLE: begin
					div_quo_q <= DVW'(fwd_mag);
					div_den_q <= DDW'(res_mm);
					div_neg_q <= s_axis_tdata[15];
					div_run_q <= in_xfer && (s_axis_tuser == hgb_pkg::REQ_ADD);
				end
				S_PROW: begin
					div_quo_q <= col_mag;
					div_den_q <= DDW'({res_mm, 1'b0});
					div_neg_q <= col_num[DVW-1];
					div_run_q <= 1'b1;
				end
				S_RCELL: begin
					div_quo_q <= DVW'(sum_mag);
					div_den_q <= DDW'(rd_cnt);
					div_neg_q <= rd_sum[SW-1];
					div_run_q <= (rd_cnt != '0);
				end
				S_RTOP_AC, S_RBOT_AC: begin
					div_quo_q <= DVW'(acc_mag);
					div_den_q <= DDW'(k_q);
					div_neg_q <= acc_new[SW-1];
					div_run_q <= (i_q + CNTW'(1) == k_q);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_go) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + CAW'(1);
					if (clr_cnt_q == CAW'(NCELL - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						h_q    <= HW'($signed(cfg_off_q)) - HW'($signed(s_axis_tdata[47:32]));
						left_q <= s_axis_tdata[31:16];
						cell_q <= CAW'(s_axis_tdata[52:48]) * CAW'(MAX_COLS)
							+ CAW'(s_axis_tdata[58:53]);
						r_status_q <= 1'b1;
						r_cnt_q    <= '0;
						r_mean_q   <= '0;
						r_top_q    <= '0;
						r_bot_q    <= '0;
						r_ovf_q    <= 1'b0;
						case (hgb_pkg::req_t'(s_axis_tuser))
							hgb_pkg::REQ_ADD:   state_q <= S_PROW;
							hgb_pkg::REQ_READ:  state_q <= rd_in_grid ? S_RCELL_RD : S_OUT;
							hgb_pkg::REQ_CLEAR: begin
								clr_cnt_q <= '0;
								state_q   <= S_CLR;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_PROW: begin
					if (!div_run_q) begin
						// A negative point inside the first cell truncates to row zero.
						row_ok_q  <= !(div_neg_q && div_quo_q != '0)
							&& (div_quo_q < DVW'(rows_use));
						row_idx_q <= CAW'(div_quo_q);
						state_q   <= S_PCOL;
					end
				end
				S_PCOL: begin
					if (!div_run_q) begin
						cell_q <= row_idx_q * CAW'(MAX_COLS) + CAW'(div_quo_q);
						if (row_ok_q && !(div_neg_q && div_quo_q != '0)
								&& (div_quo_q < DVW'(cols_use))) begin
							state_q <= S_PCELL_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_PCELL_RD: state_q <= S_PCELL;
				S_PCELL: begin
					cur_cnt_q <= rd_cnt;
					cur_sum_q <= rd_sum;
					cur_ovf_q <= rd_ovf;
					j_q       <= CIW'(rd_cnt);
					state_q   <= (rd_cnt >= CNTW'(CELL_CAP)) ? S_IDLE : S_PSCAN;
				end
				S_PSCAN: begin
					state_q <= (j_q == '0) ? S_IDLE : S_PCMP;
				end
				S_PCMP: begin
					// Lower heights move up one place until the new one finds its slot.
					if (ins_pos_hit) begin
						j_q     <= j_q - CIW'(1);
						state_q <= S_PSCAN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RCELL_RD: state_q <= S_RCELL;
				S_RCELL: begin
					n_q        <= rd_cnt;
					r_status_q <= 1'b0;
					r_cnt_q    <= 7'(rd_cnt);
					r_ovf_q    <= rd_ovf;
					state_q    <= (rd_cnt == '0) ? S_OUT : S_RMEAN;
				end
				S_RMEAN: begin
					if (!div_run_q) begin
						r_mean_q <= HW'(div_sres);
						state_q  <= S_RK;
					end
				end
				S_RK: begin
					k_q     <= CNTW'(k_prod >> hgb_pkg::TAIL_SHIFT);
					i_q     <= '0;
					acc_q   <= '0;
					state_q <= S_RTOP_RD;
				end
				S_RTOP_RD: state_q <= S_RTOP_AC;
				S_RTOP_AC: begin
					acc_q   <= acc_new;
					i_q     <= i_q + CNTW'(1);
					state_q <= (i_q + CNTW'(1) == k_q) ? S_RTOPDIV : S_RTOP_RD;
				end
				S_RTOPDIV: begin
					if (!div_run_q) begin
						r_top_q <= HW'(div_sres);
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= S_RBOT_RD;
					end
				end
				S_RBOT_RD: state_q <= S_RBOT_AC;
				S_RBOT_AC: begin
					acc_q   <= acc_new;
					i_q     <= i_q + CNTW'(1);
					state_q <= (i_q + CNTW'(1) == k_q) ? S_RBOTDIV : S_RBOT_RD;
				end
				S_RBOTDIV: begin
					if (!div_run_q) begin
						r_bot_q <= HW'(div_sres);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_go) begin
						m_user_q  <= r_status_q;
						m_data_q  <= {5'd0, r_ovf_q, r_bot_q, r_top_q, r_mean_q, r_cnt_q};
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HGB_ASSERT_IMPLY(a_idle_div_quiet, s_axis_tready, !div_run_q, "divider busy while idle")
	`HGB_ASSERT_IMPLY(a_scan_nonzero, state_q == S_PCMP, j_q != '0, "compare with empty slot")
	`HGB_ASSERT_NEXT(a_out_loads, out_go, m_axis_tvalid, "result transfer not offered")
	`HGB_ASSERT_IMPLY(a_div_count, div_run_q, div_cnt_q < DCW'(DVW), "divider overran")

endmodule
